// ===== rtl/tlsg_pkg.sv =====
// Shared constants, register map and color helpers for the thick line span generator.
package tlsg_pkg;

    localparam int MAX_THICKNESS_DEF = 32;
    localparam int COORD_BITS_DEF    = 16;

    localparam int IN_COORD_W = 16;
    localparam int DIM_W      = 14;
    localparam int THICK_W    = 6;
    localparam int COLOR_W    = 8;
    localparam int SPAN_W     = 13;
    localparam int LEN_W      = 7;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = ADDR_W - 2;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_THICKNESS    = 3'd2;
    localparam logic [IDX_W-1:0] REG_RED          = 3'd3;
    localparam logic [IDX_W-1:0] REG_GREEN        = 3'd4;
    localparam logic [IDX_W-1:0] REG_BLUE         = 3'd5;

    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 14'd1920;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 14'd1080;
    localparam logic [THICK_W-1:0] THICK_RESET  = 6'd1;
    localparam logic [DIM_W-1:0]   DIM_MAX      = 14'd8192;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    localparam int COLOR_SHIFT = 20;
    localparam int ACC_W       = 32;
    localparam int Q_W         = ACC_W - COLOR_SHIFT;

    typedef logic signed [ACC_W-1:0] t_acc;

    localparam t_acc COEF_YR = 32'sd269484;
    localparam t_acc COEF_YG = 32'sd528482;
    localparam t_acc COEF_YB = 32'sd102760;
    localparam t_acc COEF_UR = -32'sd155188;
    localparam t_acc COEF_UG = -32'sd305135;
    localparam t_acc COEF_UB = 32'sd460324;
    localparam t_acc COEF_VR = 32'sd460324;
    localparam t_acc COEF_VG = -32'sd385875;
    localparam t_acc COEF_VB = -32'sd74448;

    localparam t_acc ROUND_Y = t_acc'((1 <<< (COLOR_SHIFT - 1)) + (16 <<< COLOR_SHIFT));
    localparam t_acc ROUND_C = t_acc'((1 <<< (COLOR_SHIFT - 1)) + (128 <<< COLOR_SHIFT));

    localparam logic [COLOR_W-1:0] SAT_MAX = 8'd255;

    function automatic t_acc color_acc(
        input logic [COLOR_W-1:0] r,
        input logic [COLOR_W-1:0] g,
        input logic [COLOR_W-1:0] b,
        input t_acc               cr,
        input t_acc               cg,
        input t_acc               cb,
        input t_acc               rnd
    );
        t_acc sr;
        t_acc sg;
        t_acc sb;
        sr = $signed({{(ACC_W-COLOR_W){1'b0}}, r});
        sg = $signed({{(ACC_W-COLOR_W){1'b0}}, g});
        sb = $signed({{(ACC_W-COLOR_W){1'b0}}, b});
        return sr * cr + sg * cg + sb * cb + rnd;
    endfunction

    function automatic logic [COLOR_W-1:0] sat8(input t_acc acc);
        logic [Q_W-1:0] q;
        q = acc[ACC_W-1:COLOR_SHIFT];
        if (acc < 0) begin
            return '0;
        end else if (q > Q_W'(SAT_MAX)) begin
            return SAT_MAX;
        end else begin
            return q[COLOR_W-1:0];
        end
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (v > DIM_MAX) begin
            return DIM_MAX;
        end else begin
            return v;
        end
    endfunction

endpackage

// ===== rtl/thick_line_span_generator.sv =====
// Top level of the thick line span generator: config port, line stepper and span emitter.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one request per beat. A load request
//   latches both endpoints and yields one set of spans at the start point; a step request
//   moves one pixel, yielding a set of spans on a major-axis move, nothing on a minor-axis
//   move, or a single done beat once the major axis has reached its end.
//   Output channel (o_out_valid / i_out_ready) carries one span per beat; o_last_of_run
//   marks the final beat of a request. A set holds as many spans as the thickness (max
//   MAX_THICKNESS).
//   A request's first beat passes the span job register, then the output register.
//   Throughput: unless the output stalls, the span emitter sends one beat per cycle; the
//   next request is accepted in the cycle its predecessor's last beat enters the output
//   register. Requests with no beats do not occupy the span emitter.
//   Stall: while the output beat waits, one further request with beats is accepted and held;
//   the input then stalls until that request's last beat enters the output register.
//   Reset: line state clears to zero and registers return to their defaults; no sweep.
//   Config (APB, pready tied high) must be written only while the block is idle; the block
//   itself does not enforce this.
module thick_line_span_generator #(
    parameter int MAX_THICKNESS = tlsg_pkg::MAX_THICKNESS_DEF,
    parameter int COORD_BITS    = tlsg_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tlsg_pkg::ADDR_W-1:0]           paddr,
    input  logic [tlsg_pkg::DATA_W-1:0]           pwdata,
    output logic [tlsg_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_req_type,
    input  logic signed [tlsg_pkg::IN_COORD_W-1:0] i_start_x,
    input  logic signed [tlsg_pkg::IN_COORD_W-1:0] i_start_y,
    input  logic signed [tlsg_pkg::IN_COORD_W-1:0] i_end_x,
    input  logic signed [tlsg_pkg::IN_COORD_W-1:0] i_end_y,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [tlsg_pkg::SPAN_W-1:0]           o_span_row,
    output logic [tlsg_pkg::SPAN_W-1:0]           o_span_col,
    output logic [tlsg_pkg::LEN_W-1:0]            o_span_len,
    output logic [tlsg_pkg::COLOR_W-1:0]          o_luma,
    output logic [tlsg_pkg::COLOR_W-1:0]          o_chroma_u,
    output logic [tlsg_pkg::COLOR_W-1:0]          o_chroma_v,
    output logic                                  o_line_done,
    output logic                                  o_last_of_run
);
    import tlsg_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;
    localparam int PW   = CB + 2;
    localparam int EW   = (PW > DIM_W + 1) ? PW : DIM_W + 1;
    localparam int ERRW = CB + 4;
    localparam int TW   = $clog2(MAX_THICKNESS + 1);

    // configuration registers
    logic [DIM_W-1:0]   r_cfg_width;
    logic [DIM_W-1:0]   r_cfg_height;
    logic [THICK_W-1:0] r_cfg_thick;
    logic [COLOR_W-1:0] r_cfg_red;
    logic [COLOR_W-1:0] r_cfg_green;
    logic [COLOR_W-1:0] r_cfg_blue;

    logic             cfg_wr;
    logic [IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
            r_cfg_thick  <= THICK_RESET;
            r_cfg_red    <= '0;
            r_cfg_green  <= '0;
            r_cfg_blue   <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  r_cfg_width  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg_height <= pwdata[DIM_W-1:0];
                REG_THICKNESS:    r_cfg_thick  <= pwdata[THICK_W-1:0];
                REG_RED:          r_cfg_red    <= pwdata[COLOR_W-1:0];
                REG_GREEN:        r_cfg_green  <= pwdata[COLOR_W-1:0];
                REG_BLUE:         r_cfg_blue   <= pwdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = DATA_W'(r_cfg_width);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(r_cfg_height);
            REG_THICKNESS:    prdata = DATA_W'(r_cfg_thick);
            REG_RED:          prdata = DATA_W'(r_cfg_red);
            REG_GREEN:        prdata = DATA_W'(r_cfg_green);
            REG_BLUE:         prdata = DATA_W'(r_cfg_blue);
            default:          prdata = '0;
        endcase
    end

    // derived drawing parameters
    logic [THICK_W:0]   thick_ext;
    logic [TW-1:0]      thick;
    logic [TW-1:0]      w1;
    logic [LEN_W-1:0]   len0;
    logic [DIM_W-1:0]   img_w;
    logic [DIM_W-1:0]   img_h;

    assign thick_ext = {1'b0, r_cfg_thick};
    assign thick     = (thick_ext > (THICK_W + 1)'(MAX_THICKNESS)) ? TW'(MAX_THICKNESS)
                                                                 : TW'(thick_ext);
    assign w1        = thick >> 1;
    assign len0      = (thick == TW'(1)) ? LEN_W'(2) : LEN_W'(thick);
    assign img_w     = clamp_dim(r_cfg_width);
    assign img_h     = clamp_dim(r_cfg_height);

    logic [COLOR_W-1:0] r_luma;
    logic [COLOR_W-1:0] r_chroma_u;
    logic [COLOR_W-1:0] r_chroma_v;

    always_ff @(posedge i_clk) begin
        r_luma     <= sat8(color_acc(r_cfg_red, r_cfg_green, r_cfg_blue,
                                     COEF_YR, COEF_YG, COEF_YB, ROUND_Y));
        r_chroma_u <= sat8(color_acc(r_cfg_red, r_cfg_green, r_cfg_blue,
                                     COEF_UR, COEF_UG, COEF_UB, ROUND_C));
        r_chroma_v <= sat8(color_acc(r_cfg_red, r_cfg_green, r_cfg_blue,
                                     COEF_VR, COEF_VG, COEF_VB, ROUND_C));
    end

    // line state
    logic signed [CB-1:0]   r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic [DW-1:0]          r_adx, r_ady;
    logic signed [ERRW-1:0] r_err;
    logic                   r_xinc, r_yinc, r_xmaj;

    logic signed [CB-1:0]   n_cur_x, n_cur_y, n_tgt_x, n_tgt_y;
    logic [DW-1:0]          n_adx, n_ady;
    logic signed [ERRW-1:0] n_err;
    logic                   n_xinc, n_yinc, n_xmaj;
    logic                   n_job_set, n_job_done;

    logic signed [CB-1:0]   ld_sx, ld_sy, ld_tx, ld_ty;
    logic signed [DW-1:0]   ld_dx, ld_dy;
    logic [DW-1:0]          ld_adx, ld_ady;
    logic                   ld_xmaj;
    logic signed [ERRW-1:0] ld_two_adx, ld_two_ady;

    logic                   st_at_end;
    logic signed [CB-1:0]   step_x, step_y;
    logic signed [ERRW-1:0] two_adx, two_ady;

    logic in_fire;

    assign ld_sx = CB'(i_start_x);
    assign ld_sy = CB'(i_start_y);
    assign ld_tx = CB'(i_end_x);
    assign ld_ty = CB'(i_end_y);
    assign ld_dx = DW'(ld_tx) - DW'(ld_sx);
    assign ld_dy = DW'(ld_ty) - DW'(ld_sy);
    assign ld_adx = ld_dx[DW-1] ? DW'(-ld_dx) : DW'(ld_dx);
    assign ld_ady = ld_dy[DW-1] ? DW'(-ld_dy) : DW'(ld_dy);
    assign ld_xmaj = ld_adx > ld_ady;
    assign ld_two_adx = $signed(ERRW'({ld_adx, 1'b0}));
    assign ld_two_ady = $signed(ERRW'({ld_ady, 1'b0}));

    assign st_at_end = r_xmaj ? (r_cur_x == r_tgt_x) : (r_cur_y == r_tgt_y);
    assign step_x    = r_xinc ? r_cur_x + CB'(1) : r_cur_x - CB'(1);
    assign step_y    = r_yinc ? r_cur_y + CB'(1) : r_cur_y - CB'(1);
    assign two_adx   = $signed(ERRW'({r_adx, 1'b0}));
    assign two_ady   = $signed(ERRW'({r_ady, 1'b0}));

    always_comb begin
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_tgt_x    = r_tgt_x;
        n_tgt_y    = r_tgt_y;
        n_adx      = r_adx;
        n_ady      = r_ady;
        n_err      = r_err;
        n_xinc     = r_xinc;
        n_yinc     = r_yinc;
        n_xmaj     = r_xmaj;
        n_job_set  = 1'b0;
        n_job_done = 1'b0;
        if (in_fire) begin
            if (i_req_type == REQ_LOAD) begin
                n_cur_x   = ld_sx;
                n_cur_y   = ld_sy;
                n_tgt_x   = ld_tx;
                n_tgt_y   = ld_ty;
                n_adx     = ld_adx;
                n_ady     = ld_ady;
                n_xinc    = !ld_dx[DW-1] && (ld_dx != '0);
                n_yinc    = !ld_dy[DW-1] && (ld_dy != '0);
                n_xmaj    = ld_xmaj;
                n_err     = ld_xmaj ? ld_two_ady - $signed(ERRW'(ld_adx))
                                    : ld_two_adx - $signed(ERRW'(ld_ady));
                n_job_set = 1'b1;
            end else if (st_at_end) begin
                n_job_done = 1'b1;
            end else if (r_xmaj) begin
                if (r_err[ERRW-1]) begin
                    n_cur_x   = step_x;
                    n_err     = r_err + two_ady;
                    n_job_set = 1'b1;
                end else begin
                    n_cur_y = step_y;
                    n_err   = r_err - two_adx;
                end
            end else begin
                if (r_err[ERRW-1]) begin
                    n_cur_y   = step_y;
                    n_err     = r_err + two_adx;
                    n_job_set = 1'b1;
                end else begin
                    n_cur_x = step_x;
                    n_err   = r_err - two_ady;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_tgt_x <= '0;
            r_tgt_y <= '0;
            r_adx   <= '0;
            r_ady   <= '0;
            r_err   <= '0;
            r_xinc  <= 1'b0;
            r_yinc  <= 1'b0;
            r_xmaj  <= 1'b0;
        end else begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_tgt_x <= n_tgt_x;
            r_tgt_y <= n_tgt_y;
            r_adx   <= n_adx;
            r_ady   <= n_ady;
            r_err   <= n_err;
            r_xinc  <= n_xinc;
            r_yinc  <= n_yinc;
            r_xmaj  <= n_xmaj;
        end
    end

    // span job register
    logic                 r_job_valid;
    logic                 r_job_done;
    logic                 r_job_xmaj;
    logic signed [PW-1:0] r_job_pos;
    logic signed [CB-1:0] r_job_fix;
    logic [TW-1:0]        r_job_cnt;

    logic                 job_new;
    logic signed [PW-1:0] job_pos;
    logic signed [CB-1:0] job_fix;
    logic                 out_load;
    logic                 emit;
    logic                 job_last;
    logic                 job_free;

    assign job_new = in_fire && (n_job_done || (n_job_set && (thick != '0)));
    assign job_pos = (n_xmaj ? PW'(n_cur_y) : PW'(n_cur_x)) - $signed(PW'(w1));
    assign job_fix = n_xmaj ? n_cur_x : n_cur_y;

    assign out_load   = !o_out_valid || i_out_ready;
    assign emit       = r_job_valid && out_load;
    assign job_last   = r_job_done || (r_job_cnt == thick - TW'(1));
    assign job_free   = !r_job_valid || (emit && job_last);
    assign o_in_ready = job_free;
    assign in_fire    = i_in_valid && job_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (job_free) begin
            r_job_valid <= job_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_free) begin
            r_job_done <= n_job_done;
            r_job_xmaj <= n_xmaj;
            r_job_pos  <= job_pos;
            r_job_fix  <= job_fix;
            r_job_cnt  <= '0;
        end else if (emit) begin
            r_job_pos <= r_job_pos + PW'(1);
            r_job_cnt <= r_job_cnt + TW'(1);
        end
    end

    // span clipping
    function automatic logic [SPAN_W-1:0] clamp_coord(
        input logic signed [EW-1:0] v,
        input logic [DIM_W-1:0]     dim
    );
        logic signed [EW-1:0] d;
        d = $signed(EW'(dim));
        if (v < 0) begin
            return '0;
        end else if (v >= d) begin
            return SPAN_W'(dim - DIM_W'(1));
        end else begin
            return SPAN_W'(v);
        end
    endfunction

    logic signed [EW-1:0] pos_ext, fix_ext;
    logic [SPAN_W-1:0]    span_row, span_col;
    logic [DIM_W:0]       col_end;
    logic [DIM_W-1:0]     w_lim;
    logic [LEN_W-1:0]     span_len;

    assign pos_ext  = EW'(r_job_pos);
    assign fix_ext  = EW'(r_job_fix);
    assign span_row = clamp_coord(r_job_xmaj ? pos_ext : fix_ext, img_h);
    assign span_col = clamp_coord(r_job_xmaj ? fix_ext : pos_ext, img_w);
    assign col_end  = (DIM_W + 1)'(span_col) + (DIM_W + 1)'(len0);
    assign w_lim    = img_w - DIM_W'(1);
    assign span_len = (col_end > (DIM_W + 1)'(w_lim)) ? LEN_W'(w_lim - DIM_W'(span_col))
                                                       : len0;

    // output register
    logic                r_out_valid;
    logic [SPAN_W-1:0]   r_out_row, r_out_col;
    logic [LEN_W-1:0]    r_out_len;
    logic [COLOR_W-1:0]  r_out_y, r_out_u, r_out_v;
    logic                r_out_done, r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (r_job_done) begin
                r_out_row  <= '0;
                r_out_col  <= '0;
                r_out_len  <= '0;
                r_out_y    <= '0;
                r_out_u    <= '0;
                r_out_v    <= '0;
                r_out_done <= 1'b1;
                r_out_last <= 1'b1;
            end else begin
                r_out_row  <= span_row;
                r_out_col  <= span_col;
                r_out_len  <= span_len;
                r_out_y    <= r_luma;
                r_out_u    <= r_chroma_u;
                r_out_v    <= r_chroma_v;
                r_out_done <= 1'b0;
                r_out_last <= job_last;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_span_row    = r_out_row;
    assign o_span_col    = r_out_col;
    assign o_span_len    = r_out_len;
    assign o_luma        = r_out_y;
    assign o_chroma_u    = r_out_u;
    assign o_chroma_v    = r_out_v;
    assign o_line_done   = r_out_done;
    assign o_last_of_run = r_out_last;

endmodule

// ===== rtl/tlsg_checker.sv =====
// Port-level assertions for the thick line span generator and their bind.
module tlsg_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [tlsg_pkg::SPAN_W-1:0]   o_span_row,
    input logic [tlsg_pkg::SPAN_W-1:0]   o_span_col,
    input logic [tlsg_pkg::LEN_W-1:0]    o_span_len,
    input logic                          o_line_done,
    input logic                          o_last_of_run
);
    import tlsg_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output beat present right after reset");

    a_done_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_done |->
            o_last_of_run && o_span_len == '0 && o_span_row == '0 && o_span_col == '0)
        else $error("done beat carries span data or is not last");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_line_done |-> o_span_len <= LEN_W'(64))
        else $error("span length out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_span_row) && $stable(o_span_col)
            && $stable(o_span_len) && $stable(o_line_done) && $stable(o_last_of_run))
        else $error("stalled output beat changed");

endmodule

bind thick_line_span_generator tlsg_checker u_tlsg_checker (.*);
